// File: design/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pfb_pkg.sv
`default_nettype none
package pfb_pkg;

    typedef enum logic [2:0] {
        MODE_YUV   = 3'd0,
        MODE_RGB24 = 3'd1,
        MODE_BGR24 = 3'd2,
        MODE_RGBA  = 3'd3,
        MODE_BGRA  = 3'd4
    } pixel_mode_t;

    localparam int unsigned MAG_W  = 8;
    localparam int unsigned PROD_W = 18;
    localparam int unsigned SUM_W  = 11;

    localparam logic [7:0] CHROMA_OFFSET = 8'd128;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

    localparam logic [PROD_W-1:0] COEF_RV = 18'd1402;
    localparam logic [PROD_W-1:0] COEF_GU = 18'd344;
    localparam logic [PROD_W-1:0] COEF_GV = 18'd714;
    localparam logic [PROD_W-1:0] COEF_BU = 18'd1772;

    // floor(m / 1000) == (m * RECIP_1000) >> RECIP_SHIFT for every m below 2^18.
    localparam int unsigned RECIP_W     = 19;
    localparam int unsigned RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;
    localparam int unsigned QPROD_W = PROD_W + RECIP_W;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
        logic       is_yuv;
        logic       swap_rb;
        logic       pass_alpha;
        logic       u_neg;
        logic       v_neg;
    } pix_ctl_t;

    function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] signed_term(input logic [7:0] q,
                                                            input logic       neg);
        logic signed [SUM_W-1:0] t;
        t = $signed({{(SUM_W-8){1'b0}}, q});
        return neg ? -t : t;
    endfunction

endpackage
`default_nettype wire

// File: design/pixel_format_to_bgra_core.sv
`default_nettype none
// Pixel format to BGRA8 converter.
// Input channel: pixel_valid / pixel_stall carry one pixel per transaction in
// first_component .. fourth_component (Y, U, V in YUV mode, else raw bytes).
// Output channel: result_valid / result_stall carry blue_out, green_out,
// red_out and alpha_out, one result per accepted pixel, in order.
// Mode port: mode_valid / mode_ready write pixel_mode (0 YUV, 1 RGB24,
// 2 BGR24, 3 RGBA, 4 BGRA). mode_ready is always high. Write it only while
// the pipeline is empty. A pixel taken under modes 5 to 7 is dropped.
// Four register stages lie between acceptance and result_valid: input and chroma
// magnitude, coefficient multiply, reciprocal multiply for the divide by
// 1000, then sum, saturate and swizzle into the output register.
// Throughput is one pixel per clock unless result_stall backs the pipeline up.
// When the receiver stalls, results pile up in the empty stages behind the
// output register, so pixel_stall rises only once all four stages are full.
// Reset empties the pipeline and sets the mode to YUV.
module pixel_format_to_bgra_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mode_valid,
    output logic            mode_ready,
    input  wire logic [2:0] pixel_mode,
    input  wire logic       pixel_valid,
    output logic            pixel_stall,
    input  wire logic [7:0] first_component,
    input  wire logic [7:0] second_component,
    input  wire logic [7:0] third_component,
    input  wire logic [7:0] fourth_component,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      blue_out,
    output logic [7:0]      green_out,
    output logic [7:0]      red_out,
    output logic [7:0]      alpha_out
);

    logic [2:0] mode_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4;

    pfb_pkg::pix_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    pfb_pkg::pix_ctl_t s1_ctl_next;
    logic              s1_ok_next;

    logic [pfb_pkg::MAG_W-1:0] u_mag_reg, v_mag_reg, u_mag_next, v_mag_next;

    logic [pfb_pkg::PROD_W-1:0] prod_rv_reg, prod_gu_reg, prod_gv_reg, prod_bu_reg;
    logic [pfb_pkg::PROD_W-1:0] prod_rv_next, prod_gu_next, prod_gv_next, prod_bu_next;

    logic [7:0] q_rv_reg, q_gu_reg, q_gv_reg, q_bu_reg;
    logic [pfb_pkg::QPROD_W-1:0] qp_rv, qp_gu, qp_gv, qp_bu;

    logic [7:0] blue_reg, green_reg, red_reg, alpha_reg;
    logic [7:0] blue_next, green_next, red_next, alpha_next;

    logic signed [pfb_pkg::SUM_W-1:0] y_s, r_sum, g_sum, b_sum;

    // Each stage moves when it is empty or the stage after it moves.
    assign en4 = !out_valid_reg || !result_stall;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign pixel_stall = !en1;
    assign mode_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pfb_pkg::MODE_YUV;
        end
        else if (mode_valid && mode_ready)
        begin
            mode_reg <= pixel_mode;
        end
    end

    // Stage 1: decode the mode and take the chroma values apart into sign and magnitude.
    always_comb
    begin
        s1_ctl_next.c0         = first_component;
        s1_ctl_next.c1         = second_component;
        s1_ctl_next.c2         = third_component;
        s1_ctl_next.c3         = fourth_component;
        s1_ctl_next.is_yuv     = 1'b0;
        s1_ctl_next.swap_rb    = 1'b0;
        s1_ctl_next.pass_alpha = 1'b0;
        s1_ctl_next.u_neg      = second_component < pfb_pkg::CHROMA_OFFSET;
        s1_ctl_next.v_neg      = third_component < pfb_pkg::CHROMA_OFFSET;
        s1_ok_next             = 1'b1;
        case (mode_reg)
            pfb_pkg::MODE_YUV:   s1_ctl_next.is_yuv = 1'b1;
            pfb_pkg::MODE_RGB24: s1_ctl_next.swap_rb = 1'b1;
            pfb_pkg::MODE_BGR24: s1_ctl_next.swap_rb = 1'b0;
            pfb_pkg::MODE_RGBA:
            begin
                s1_ctl_next.swap_rb    = 1'b1;
                s1_ctl_next.pass_alpha = 1'b1;
            end
            pfb_pkg::MODE_BGRA:  s1_ctl_next.pass_alpha = 1'b1;
            default:             s1_ok_next = 1'b0;
        endcase
        u_mag_next = s1_ctl_next.u_neg ? pfb_pkg::CHROMA_OFFSET - second_component
                                       : second_component - pfb_pkg::CHROMA_OFFSET;
        v_mag_next = s1_ctl_next.v_neg ? pfb_pkg::CHROMA_OFFSET - third_component
                                       : third_component - pfb_pkg::CHROMA_OFFSET;
    end

    // Stage 2 products: magnitude times coefficient.
    assign prod_rv_next = pfb_pkg::PROD_W'(v_mag_reg) * pfb_pkg::COEF_RV;
    assign prod_gu_next = pfb_pkg::PROD_W'(u_mag_reg) * pfb_pkg::COEF_GU;
    assign prod_gv_next = pfb_pkg::PROD_W'(v_mag_reg) * pfb_pkg::COEF_GV;
    assign prod_bu_next = pfb_pkg::PROD_W'(u_mag_reg) * pfb_pkg::COEF_BU;

    // Stage 3: divide the magnitudes by 1000; truncating the magnitude
    // matches truncation toward zero once the sign goes back on.
    assign qp_rv = pfb_pkg::QPROD_W'(prod_rv_reg) * pfb_pkg::QPROD_W'(pfb_pkg::RECIP_1000);
    assign qp_gu = pfb_pkg::QPROD_W'(prod_gu_reg) * pfb_pkg::QPROD_W'(pfb_pkg::RECIP_1000);
    assign qp_gv = pfb_pkg::QPROD_W'(prod_gv_reg) * pfb_pkg::QPROD_W'(pfb_pkg::RECIP_1000);
    assign qp_bu = pfb_pkg::QPROD_W'(prod_bu_reg) * pfb_pkg::QPROD_W'(pfb_pkg::RECIP_1000);

    // Stage 4: sum, saturate and pick the byte order.
    always_comb
    begin
        y_s   = $signed({{(pfb_pkg::SUM_W-8){1'b0}}, s3_ctl_reg.c0});
        r_sum = y_s + pfb_pkg::signed_term(q_rv_reg, s3_ctl_reg.v_neg);
        g_sum = y_s - pfb_pkg::signed_term(q_gu_reg, s3_ctl_reg.u_neg)
                    - pfb_pkg::signed_term(q_gv_reg, s3_ctl_reg.v_neg);
        b_sum = y_s + pfb_pkg::signed_term(q_bu_reg, s3_ctl_reg.u_neg);
        if (s3_ctl_reg.is_yuv)
        begin
            blue_next  = pfb_pkg::sat8(b_sum);
            green_next = pfb_pkg::sat8(g_sum);
            red_next   = pfb_pkg::sat8(r_sum);
        end
        else if (s3_ctl_reg.swap_rb)
        begin
            blue_next  = s3_ctl_reg.c2;
            green_next = s3_ctl_reg.c1;
            red_next   = s3_ctl_reg.c0;
        end
        else
        begin
            blue_next  = s3_ctl_reg.c0;
            green_next = s3_ctl_reg.c1;
            red_next   = s3_ctl_reg.c2;
        end
        alpha_next = s3_ctl_reg.pass_alpha ? s3_ctl_reg.c3 : pfb_pkg::ALPHA_OPAQUE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= pixel_valid && s1_ok_next;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ctl_reg <= s1_ctl_next;
            u_mag_reg  <= u_mag_next;
            v_mag_reg  <= v_mag_next;
        end
        if (en2)
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            prod_rv_reg <= prod_rv_next;
            prod_gu_reg <= prod_gu_next;
            prod_gv_reg <= prod_gv_next;
            prod_bu_reg <= prod_bu_next;
        end
        if (en3)
        begin
            s3_ctl_reg <= s2_ctl_reg;
            q_rv_reg   <= qp_rv[pfb_pkg::RECIP_SHIFT +: 8];
            q_gu_reg   <= qp_gu[pfb_pkg::RECIP_SHIFT +: 8];
            q_gv_reg   <= qp_gv[pfb_pkg::RECIP_SHIFT +: 8];
            q_bu_reg   <= qp_bu[pfb_pkg::RECIP_SHIFT +: 8];
        end
        if (en4)
        begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
            alpha_reg <= alpha_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign blue_out     = blue_reg;
    assign green_out    = green_reg;
    assign red_out      = red_reg;
    assign alpha_out    = alpha_reg;

endmodule
`default_nettype wire

// File: design/pfb_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pfb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       mode_valid,
    input wire logic       mode_ready,
    input wire logic [2:0] pixel_mode,
    input wire logic       pixel_valid,
    input wire logic       pixel_stall,
    input wire logic [7:0] first_component,
    input wire logic [7:0] second_component,
    input wire logic [7:0] third_component,
    input wire logic [7:0] fourth_component,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] blue_out,
    input wire logic [7:0] green_out,
    input wire logic [7:0] red_out,
    input wire logic [7:0] alpha_out
);

    // A stalled result keeps its valid and its payload.
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(blue_out) && $stable(green_out)
            && $stable(red_out) && $stable(alpha_out),
        "stalled result changed")

    // The pipeline comes out of reset empty.
    `ASSERT_NOW(a_reset_empty, clk, rst_n, $past(!rst_n), !result_valid, "result right after reset")

    // With an empty output register every stage can advance, so no input stall.
    `ASSERT_NOW(a_no_stall_when_empty, clk, rst_n, !result_valid, !pixel_stall, "input stalled while output empty")

endmodule

bind pixel_format_to_bgra_core pfb_checker u_pfb_checker (.*);
`default_nettype wire
